[design/eebb_pkg.sv]
// Shared types and constants for the elliptical edge blur blend block.
// Used by the channel interfaces and the top level.
package eebb_pkg;

   // fixed field widths
   localparam int COORD_W      = 12;
   localparam int CHAN_W       = 8;
   localparam int CFG_DIM_W    = 13;
   localparam int CFG_INDENT_W = 11;

   // csr port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_INDENT_LEFT  = 2'd2,
      REG_INDENT_TOP   = 2'd3
   } csr_reg_type;

   // register reset values
   localparam logic [CFG_DIM_W-1:0]    RST_IMAGE_WIDTH  = 13'd640;
   localparam logic [CFG_DIM_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;
   localparam logic [CFG_INDENT_W-1:0] RST_INDENT_LEFT  = 11'd0;
   localparam logic [CFG_INDENT_W-1:0] RST_INDENT_TOP   = 11'd0;

   // source and blurred channels of one pixel, carried down the pipe
   typedef struct packed {
      logic [CHAN_W-1:0] src0;
      logic [CHAN_W-1:0] src1;
      logic [CHAN_W-1:0] src2;
      logic [CHAN_W-1:0] blur0;
      logic [CHAN_W-1:0] blur1;
      logic [CHAN_W-1:0] blur2;
   } chans_type;

endpackage

[design/eebb_req_if.sv]
// Pixel request channel: valid/ready plus coordinates and channels.
// Depends on eebb_pkg.
interface eebb_req_if;
   import eebb_pkg::*;

   logic              valid;
   logic              ready;
   logic [COORD_W-1:0] pixel_row;
   logic [COORD_W-1:0] pixel_col;
   logic [CHAN_W-1:0]  src_chan0;
   logic [CHAN_W-1:0]  src_chan1;
   logic [CHAN_W-1:0]  src_chan2;
   logic [CHAN_W-1:0]  blur_chan0;
   logic [CHAN_W-1:0]  blur_chan1;
   logic [CHAN_W-1:0]  blur_chan2;

   modport source (
      output valid, pixel_row, pixel_col, src_chan0, src_chan1, src_chan2,
             blur_chan0, blur_chan1, blur_chan2,
      input  ready
   );

   modport sink (
      input  valid, pixel_row, pixel_col, src_chan0, src_chan1, src_chan2,
             blur_chan0, blur_chan1, blur_chan2,
      output ready
   );

endinterface

[design/eebb_rsp_if.sv]
// Blended pixel response channel: valid/ready plus three output channels.
// Depends on eebb_pkg.
interface eebb_rsp_if;
   import eebb_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_chan0;
   logic [CHAN_W-1:0] out_chan1;
   logic [CHAN_W-1:0] out_chan2;

   modport source (
      output valid, out_chan0, out_chan1, out_chan2,
      input  ready
   );

   modport sink (
      input  valid, out_chan0, out_chan1, out_chan2,
      output ready
   );

endinterface

[design/eebb_div.sv]
// Pipelined restoring divider: one quotient bit per stage, Q_W stages.
// Carries a sideband word alongside; standalone, no package needed.
module eebb_div #(
   parameter int DV_W   = 53,
   parameter int Q_W    = 16,
   parameter int SIDE_W = 49
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DV_W-1:0]   in_num,
   input  logic [DV_W-1:0]   in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [Q_W-1:0]    out_quo,
   output logic [SIDE_W-1:0] out_side
);

   // stage registers
   logic              v_ff    [Q_W];
   logic [DV_W-1:0]   r_ff    [Q_W];
   logic [DV_W-1:0]   d_ff    [Q_W];
   logic [Q_W-1:0]    q_ff    [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];

   // what each stage sees at its input
   logic              src_v    [Q_W];
   logic [DV_W-1:0]   src_r    [Q_W];
   logic [DV_W-1:0]   src_d    [Q_W];
   logic [Q_W-1:0]    src_q    [Q_W];
   logic [SIDE_W-1:0] src_side [Q_W];

   logic [DV_W:0]     trial_in [Q_W];
   logic [DV_W-1:0]   r_in     [Q_W];
   logic [Q_W-1:0]    q_in     [Q_W];
   logic [Q_W:0]      en;

   // stage feed: stage 0 from the port, others from the stage before
   always_comb begin
      src_v[0]    = in_valid;
      src_r[0]    = in_num;
      src_d[0]    = in_den;
      src_q[0]    = '0;
      src_side[0] = in_side;
      for (int k = 1; k < Q_W; k++) begin
         src_v[k]    = v_ff[k-1];
         src_r[k]    = r_ff[k-1];
         src_d[k]    = d_ff[k-1];
         src_q[k]    = q_ff[k-1];
         src_side[k] = side_ff[k-1];
      end
   end

   // shift, trial subtract, restore on borrow
   always_comb begin
      for (int k = 0; k < Q_W; k++) begin
         trial_in[k] = {src_r[k], 1'b0} - {1'b0, src_d[k]};
         if (trial_in[k][DV_W]) begin
            r_in[k] = {src_r[k][DV_W-2:0], 1'b0};
         end else begin
            r_in[k] = trial_in[k][DV_W-1:0];
         end
         q_in[k] = {src_q[k][Q_W-2:0], ~trial_in[k][DV_W]};
      end
   end

   // a stage moves when it is empty or the next one moves
   always_comb begin
      en[Q_W] = out_ready;
      for (int k = Q_W - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Q_W; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < Q_W; k++) begin
            if (en[k]) begin
               v_ff[k] <= src_v[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Q_W; k++) begin
         if (en[k]) begin
            r_ff[k]    <= r_in[k];
            d_ff[k]    <= src_d[k];
            q_ff[k]    <= q_in[k];
            side_ff[k] <= src_side[k];
         end
      end
   end

   assign out_valid = v_ff[Q_W-1];
   assign out_quo   = q_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

[design/elliptical_edge_blur_blend.sv]
// Elliptical edge blur blend, top level. Takes one pixel word per clock and
// returns one blended word per clock while the response side does not stall;
// the pipeline has five stages of ellipse arithmetic, one divider stage per
// weight bit and one blend stage. Each stage holds its word while the
// response side stalls, so nothing is dropped or repeated. The user must
// write frame size and indents through the csr port only while no pixel is
// in flight; the block itself does not enforce this. They feed the pipeline
// directly. Depends on eebb_pkg, eebb_req_if, eebb_rsp_if and eebb_div.
module elliptical_edge_blur_blend #(
   parameter int MAX_DIM          = 4096,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   eebb_req_if.sink                      req_px,
   eebb_rsp_if.source                    rsp_px,
   input  logic                          csr_we,
   input  logic [eebb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [eebb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import eebb_pkg::*;

   localparam int F      = WEIGHT_FRAC_BITS;
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int D_W    = ((DIM_W > COORD_W + 1) ? DIM_W : COORD_W + 1) + 1;
   localparam int M_W    = D_W - 1;
   localparam int SQ_W   = 2 * M_W;
   localparam int P_W    = 2 * SQ_W;
   localparam int N_W    = P_W + 2;
   localparam int DV_W   = N_W - 1;
   localparam int SIDE_W = 1 + $bits(chans_type);
   localparam int MIX_W  = CHAN_W + F + 2;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   // ---------------- configuration registers ----------------
   logic [CFG_DIM_W-1:0]    image_width_ff, image_height_ff;
   logic [CFG_INDENT_W-1:0] indent_left_ff, indent_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RST_IMAGE_WIDTH;
         image_height_ff <= RST_IMAGE_HEIGHT;
         indent_left_ff  <= RST_INDENT_LEFT;
         indent_top_ff   <= RST_INDENT_TOP;
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[CFG_DIM_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_wdata[CFG_DIM_W-1:0];
            REG_INDENT_LEFT:  indent_left_ff  <= csr_wdata[CFG_INDENT_W-1:0];
            REG_INDENT_TOP:   indent_top_ff   <= csr_wdata[CFG_INDENT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- helpers ----------------
   function automatic logic [M_W-1:0] mag(input logic signed [D_W-1:0] v);
      logic [D_W-1:0] t;
      t = v[D_W-1] ? D_W'(-v) : D_W'(v);
      return t[M_W-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] s,
                                                input logic [CHAN_W-1:0] b,
                                                input logic [F:0] wq,
                                                input logic [F:0] inv);
      logic [MIX_W-1:0] mix;
      mix = MIX_W'(b) * MIX_W'(wq) + MIX_W'(s) * MIX_W'(inv);
      return mix[F +: CHAN_W];
   endfunction

   // ---------------- stage enables ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, out_v_ff;
   logic en1, en2, en3, en4, en5, en_out;
   logic div_in_ready, div_out_valid;

   assign en_out = !out_v_ff || rsp_px.ready;
   assign en5    = !v5_ff || div_in_ready;
   assign en4    = !v4_ff || en5;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign req_px.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff    <= req_px.valid;
         if (en2)    v2_ff    <= v1_ff;
         if (en3)    v3_ff    <= v2_ff;
         if (en4)    v4_ff    <= v3_ff;
         if (en5)    v5_ff    <= v4_ff;
         if (en_out) out_v_ff <= div_out_valid;
      end
   end

   // ---------------- stage 1: clamp, doubled offsets, magnitudes ----------------
   logic [DIM_W-1:0]       w_clamp, h_clamp;
   logic signed [D_W-1:0]  dx, dy, ea, eb;
   chans_type              chans_in;
   logic [M_W-1:0]         mdx1_ff, mdy1_ff, mea1_ff, meb1_ff, w1_ff, h1_ff;
   chans_type              ch1_ff;

   always_comb begin
      w_clamp = (32'(image_width_ff) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                     : DIM_W'(image_width_ff);
      h_clamp = (32'(image_height_ff) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                      : DIM_W'(image_height_ff);
      dx = signed'(D_W'(w_clamp)) - signed'(D_W'({req_px.pixel_col, 1'b0}));
      dy = signed'(D_W'(h_clamp)) - signed'(D_W'({req_px.pixel_row, 1'b0}));
      ea = signed'(D_W'(w_clamp)) - signed'(D_W'({indent_left_ff, 1'b0}));
      eb = signed'(D_W'(h_clamp)) - signed'(D_W'({indent_top_ff, 1'b0}));
      chans_in.src0  = req_px.src_chan0;
      chans_in.src1  = req_px.src_chan1;
      chans_in.src2  = req_px.src_chan2;
      chans_in.blur0 = req_px.blur_chan0;
      chans_in.blur1 = req_px.blur_chan1;
      chans_in.blur2 = req_px.blur_chan2;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         mdx1_ff <= mag(dx);
         mdy1_ff <= mag(dy);
         mea1_ff <= mag(ea);
         meb1_ff <= mag(eb);
         w1_ff   <= M_W'(w_clamp);
         h1_ff   <= M_W'(h_clamp);
         ch1_ff  <= chans_in;
      end
   end

   // ---------------- stage 2: squares ----------------
   logic [SQ_W-1:0] dx2_ff, dy2_ff, a2_ff, b2_ff, ww2_ff, hh2_ff;
   chans_type       ch2_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         dx2_ff <= SQ_W'(mdx1_ff) * SQ_W'(mdx1_ff);
         dy2_ff <= SQ_W'(mdy1_ff) * SQ_W'(mdy1_ff);
         a2_ff  <= SQ_W'(mea1_ff) * SQ_W'(mea1_ff);
         b2_ff  <= SQ_W'(meb1_ff) * SQ_W'(meb1_ff);
         ww2_ff <= SQ_W'(w1_ff) * SQ_W'(w1_ff);
         hh2_ff <= SQ_W'(h1_ff) * SQ_W'(h1_ff);
         ch2_ff <= ch1_ff;
      end
   end

   // ---------------- stage 3: cross products ----------------
   logic [P_W-1:0] dxb3_ff, dya3_ff, ab3_ff, wb3_ff, ha3_ff;
   chans_type      ch3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         dxb3_ff <= P_W'(dx2_ff) * P_W'(b2_ff);
         dya3_ff <= P_W'(dy2_ff) * P_W'(a2_ff);
         ab3_ff  <= P_W'(a2_ff) * P_W'(b2_ff);
         wb3_ff  <= P_W'(ww2_ff) * P_W'(b2_ff);
         ha3_ff  <= P_W'(hh2_ff) * P_W'(a2_ff);
         ch3_ff  <= ch2_ff;
      end
   end

   // ---------------- stage 4: numerator and denominator ----------------
   logic signed [N_W-1:0] num4_ff, den4_ff;
   chans_type             ch4_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         num4_ff <= signed'(N_W'(dxb3_ff)) + signed'(N_W'(dya3_ff))
                    - signed'(N_W'(ab3_ff));
         den4_ff <= signed'(N_W'(wb3_ff)) + signed'(N_W'(ha3_ff))
                    - signed'(N_W'(ab3_ff));
         ch4_ff  <= ch3_ff;
      end
   end

   // ---------------- stage 5: classify, divider operands ----------------
   logic            num_pos, den_pos, sat_w, div_w;
   logic [DV_W-1:0] n5_ff, d5_ff;
   logic            sat5_ff;
   chans_type       ch5_ff;

   always_comb begin
      num_pos = !num4_ff[N_W-1] && (num4_ff != '0);
      den_pos = !den4_ff[N_W-1] && (den4_ff != '0);
      sat_w   = num_pos && den_pos &&
                (num4_ff[DV_W-1:0] >= den4_ff[DV_W-1:0]);
      div_w   = num_pos && den_pos && !sat_w;
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         // non-divide cases run with 0 / 1 so the quotient comes out zero
         n5_ff   <= div_w ? num4_ff[DV_W-1:0] : '0;
         d5_ff   <= div_w ? den4_ff[DV_W-1:0] : DV_W'(1);
         sat5_ff <= sat_w;
         ch5_ff  <= ch4_ff;
      end
   end

   // ---------------- weight divider ----------------
   logic [F-1:0]      div_quo;
   logic [SIDE_W-1:0] div_side;
   chans_type         ch_d;
   logic              sat_d;

   eebb_div #(
      .DV_W   (DV_W),
      .Q_W    (F),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_ready  (div_in_ready),
      .in_num    (n5_ff),
      .in_den    (d5_ff),
      .in_side   ({sat5_ff, ch5_ff}),
      .out_valid (div_out_valid),
      .out_ready (en_out),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // ---------------- blend and output register ----------------
   logic [F:0]        wq, inv_wq;
   logic [CHAN_W-1:0] out0_ff, out1_ff, out2_ff;

   always_comb begin
      sat_d  = div_side[SIDE_W-1];
      ch_d   = div_side[SIDE_W-2:0];
      wq     = sat_d ? ONE : {1'b0, div_quo};
      inv_wq = ONE - wq;
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         out0_ff <= blend(ch_d.src0, ch_d.blur0, wq, inv_wq);
         out1_ff <= blend(ch_d.src1, ch_d.blur1, wq, inv_wq);
         out2_ff <= blend(ch_d.src2, ch_d.blur2, wq, inv_wq);
      end
   end

   assign rsp_px.valid     = out_v_ff;
   assign rsp_px.out_chan0 = out0_ff;
   assign rsp_px.out_chan1 = out1_ff;
   assign rsp_px.out_chan2 = out2_ff;

endmodule
